>>> design/lztsd_pkg.sv
// Shared types and constants for the LZ token stream decompressor.
`timescale 1ns / 1ps
`default_nettype none

package lztsd_pkg;

    // Default sizes
    localparam int HISTORY_DEPTH_DEF = 65536;
    localparam int LENGTH_BITS_DEF   = 32;

    // Format constants
    localparam logic [2:0] HDR_LEN   = 3'd4;
    localparam logic [3:0] NIB_ESC   = 4'hF;
    localparam logic [7:0] EXT_CONT  = 8'hFF;
    localparam int         MIN_MATCH = 4;

    // Request kinds on the input channel
    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_COPY = 1'b1
    } req_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO_OFF = 3'd1,
        ST_FAR      = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_BUSY     = 3'd4
    } status_t;

    // Parser phases
    typedef enum logic [3:0] {
        PH_HDR    = 4'd0,
        PH_TOKEN  = 4'd1,
        PH_LITEXT = 4'd2,
        PH_LIT    = 4'd3,
        PH_OFF0   = 4'd4,
        PH_OFF1   = 4'd5,
        PH_MEXT   = 4'd6,
        PH_COPY   = 4'd7,
        PH_DRAIN  = 4'd8
    } phase_t;

    // Result fields other than the data byte
    typedef struct packed {
        logic        has_data;
        logic [31:0] copy_left;
        logic        block_done;
        status_t     status;
    } res_t;

endpackage

`default_nettype wire

>>> design/lztsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lztsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-first: a read at the write address returns the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/lz_token_stream_decompressor.sv
// Top level of the LZ token stream decompressor: parser, history RAM and output stage.
`timescale 1ns / 1ps
`default_nettype none

// Streaming LZ4-style block decoder. Each input beat is either one compressed
// byte (req_type 0) or one copy step (req_type 1) that replays one match byte
// from the history RAM; the block takes one beat per clock cycle while in_stall
// is low and gives at most one result beat per input beat. The result of an
// input beat passes from the write/read stage register into the output
// register: the parser state updates at accept, while the history RAM read
// (registered) and the history write happen in the following stage, with a
// forwarding path when a copy reads the byte being written in that same cycle.
// The input is stalled only while a result is held in that stage and the
// output register is full and stalled. History entries are never cleared; a
// block only reads back bytes that it has written itself.

module lz_token_stream_decompressor #(
    parameter int HISTORY_DEPTH = lztsd_pkg::HISTORY_DEPTH_DEF,
    parameter int LENGTH_BITS   = lztsd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    // Output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             has_data,
    output logic [7:0]       out_byte,
    output logic [31:0]      copy_left,
    output logic             block_done,
    output logic [2:0]       status
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int OW = ((AW > 16) ? AW : 16) + 1;
    localparam int LB = LENGTH_BITS;
    localparam logic [31:0] DEPTH32 = 32'(HISTORY_DEPTH);

    // Parser state
    lztsd_pkg::phase_t phase_reg, phase_next;
    logic [2:0]        header_left_reg, header_left_next;
    logic [3:0]        match_nibble_reg, match_nibble_next;
    logic [LB-1:0]     literal_left_reg, literal_left_next;
    logic [LB-1:0]     match_left_reg, match_left_next;
    logic [15:0]       match_offset_reg, match_offset_next;
    logic              end_seen_reg, end_seen_next;
    logic [31:0]       produced_reg, produced_next;
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;

    // Write/read stage
    logic              s1_valid_reg;
    lztsd_pkg::res_t   s1_res_reg;
    logic              s1_has_res_reg;
    logic              s1_wen_reg;
    logic [AW-1:0]     s1_waddr_reg;
    logic              s1_copy_reg;
    logic [7:0]        s1_lit_reg;
    logic              s1_fwd_reg;
    logic [7:0]        s1_fwd_data_reg;

    // Output register
    logic              out_valid_reg;
    lztsd_pkg::res_t   out_res_reg;
    logic [7:0]        out_byte_reg;

    // Combinational decode
    logic              in_accept;
    logic              s1_move;
    logic              is_copy;
    logic              copy_go;
    logic [LB-1:0]     match_dec;
    logic [LB-1:0]     lit_dec;
    logic [15:0]       off_full;
    logic              off_zero;
    logic              off_far;
    logic [LB:0]       lit_sum_raw;
    logic [LB:0]       match_sum_raw;
    logic [LB-1:0]     lit_sum;
    logic [LB-1:0]     match_sum;
    logic              push;
    logic [AW:0]       wr_inc;
    logic [OW-1:0]     rd_diff;
    logic [OW-1:0]     rd_wrap;
    logic [AW-1:0]     rd_addr;
    logic              res_valid;
    lztsd_pkg::res_t   res;
    logic              do_close;
    logic              close_drain;
    logic [7:0]        ram_q;
    logic              ram_we;
    logic [7:0]        s1_data;

    // Handshake
    assign s1_move   = !s1_valid_reg || !s1_has_res_reg || !out_valid_reg || !out_stall;
    assign in_stall  = !s1_move;
    assign in_accept = in_valid && s1_move;

    // Shared decode of the current beat
    assign is_copy   = (lztsd_pkg::req_t'(req_type) == lztsd_pkg::REQ_COPY);
    assign copy_go   = is_copy && (phase_reg == lztsd_pkg::PH_COPY) && (match_left_reg != '0);
    assign match_dec = match_left_reg - LB'(1);
    assign lit_dec   = (literal_left_reg != '0) ? (literal_left_reg - LB'(1)) : '0;
    assign off_full  = {in_byte, match_offset_reg[7:0]};
    assign off_zero  = (off_full == 16'd0);
    assign off_far   = (32'(off_full) > produced_reg) || (32'(off_full) > DEPTH32);

    // Saturating length extension
    assign lit_sum_raw   = {1'b0, literal_left_reg} + (LB + 1)'(in_byte);
    assign match_sum_raw = {1'b0, match_left_reg} + (LB + 1)'(in_byte);
    assign lit_sum       = lit_sum_raw[LB] ? '1 : lit_sum_raw[LB-1:0];
    assign match_sum     = match_sum_raw[LB] ? '1 : match_sum_raw[LB-1:0];

    // History pointers
    assign push    = copy_go || (!is_copy && (phase_reg == lztsd_pkg::PH_LIT));
    assign wr_inc  = {1'b0, wr_ptr_reg} + (AW + 1)'(1);
    assign rd_diff = OW'(wr_ptr_reg) - OW'(match_offset_reg);
    assign rd_wrap = rd_diff[OW-1] ? (rd_diff + OW'(HISTORY_DEPTH)) : rd_diff;
    assign rd_addr = rd_wrap[AW-1:0];

    // Result of the current beat
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        res.status = lztsd_pkg::ST_OK;
        if (is_copy)
        begin
            res_valid      = copy_go;
            res.has_data   = 1'b1;
            res.copy_left  = 32'(match_dec);
            res.block_done = (match_dec == '0) && end_seen_reg;
        end
        else
        begin
            case (phase_reg)
                lztsd_pkg::PH_HDR:
                begin
                    res_valid      = in_last;
                    res.block_done = 1'b1;
                    res.status     = (header_left_reg == 3'd1) ? lztsd_pkg::ST_OK
                                                               : lztsd_pkg::ST_TRUNC;
                end
                lztsd_pkg::PH_TOKEN:
                begin
                    res_valid      = in_last;
                    res.block_done = 1'b1;
                    res.status     = (in_byte[7:4] == 4'd0) ? lztsd_pkg::ST_OK
                                                            : lztsd_pkg::ST_TRUNC;
                end
                lztsd_pkg::PH_LITEXT, lztsd_pkg::PH_OFF0:
                begin
                    res_valid      = in_last;
                    res.block_done = 1'b1;
                    res.status     = lztsd_pkg::ST_TRUNC;
                end
                lztsd_pkg::PH_LIT:
                begin
                    res_valid      = 1'b1;
                    res.has_data   = 1'b1;
                    res.block_done = in_last;
                    res.status     = (in_last && (lit_dec != '0)) ? lztsd_pkg::ST_TRUNC
                                                                  : lztsd_pkg::ST_OK;
                end
                lztsd_pkg::PH_OFF1:
                begin
                    res.block_done = 1'b1;
                    if (off_zero)
                    begin
                        res_valid  = 1'b1;
                        res.status = lztsd_pkg::ST_ZERO_OFF;
                    end
                    else if (off_far)
                    begin
                        res_valid  = 1'b1;
                        res.status = lztsd_pkg::ST_FAR;
                    end
                    else
                    begin
                        res_valid  = in_last && (match_nibble_reg == lztsd_pkg::NIB_ESC);
                        res.status = lztsd_pkg::ST_TRUNC;
                    end
                end
                lztsd_pkg::PH_MEXT:
                begin
                    res_valid      = in_last && (in_byte == lztsd_pkg::EXT_CONT);
                    res.block_done = 1'b1;
                    res.status     = lztsd_pkg::ST_TRUNC;
                end
                lztsd_pkg::PH_COPY:
                begin
                    res_valid     = 1'b1;
                    res.copy_left = 32'(match_left_reg);
                    res.status    = lztsd_pkg::ST_BUSY;
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // Block closes on every finishing result, and on the last byte while draining
    assign do_close    = (res_valid && res.block_done)
                      || (!is_copy && in_last && (phase_reg == lztsd_pkg::PH_DRAIN));
    assign close_drain = !is_copy && !in_last && res_valid && res.block_done;

    // Next parser state
    always_comb
    begin
        phase_next        = phase_reg;
        header_left_next  = header_left_reg;
        match_nibble_next = match_nibble_reg;
        literal_left_next = literal_left_reg;
        match_left_next   = match_left_reg;
        match_offset_next = match_offset_reg;
        end_seen_next     = end_seen_reg;
        produced_next     = produced_reg;
        wr_ptr_next       = wr_ptr_reg;

        if (is_copy)
        begin
            if (copy_go)
            begin
                match_left_next = match_dec;
                if (match_dec == '0)
                begin
                    phase_next = lztsd_pkg::PH_TOKEN;
                end
            end
        end
        else
        begin
            case (phase_reg)
                lztsd_pkg::PH_HDR:
                begin
                    header_left_next = header_left_reg - 3'd1;
                    if (header_left_reg == 3'd1)
                    begin
                        phase_next = lztsd_pkg::PH_TOKEN;
                    end
                end
                lztsd_pkg::PH_TOKEN:
                begin
                    match_nibble_next = in_byte[3:0];
                    literal_left_next = LB'(in_byte[7:4]);
                    if (in_byte[7:4] == lztsd_pkg::NIB_ESC)
                    begin
                        phase_next = lztsd_pkg::PH_LITEXT;
                    end
                    else if (in_byte[7:4] != 4'd0)
                    begin
                        phase_next = lztsd_pkg::PH_LIT;
                    end
                    else
                    begin
                        phase_next = lztsd_pkg::PH_OFF0;
                    end
                end
                lztsd_pkg::PH_LITEXT:
                begin
                    literal_left_next = lit_sum;
                    if (in_byte != lztsd_pkg::EXT_CONT)
                    begin
                        phase_next = lztsd_pkg::PH_LIT;
                    end
                end
                lztsd_pkg::PH_LIT:
                begin
                    literal_left_next = lit_dec;
                    if (lit_dec == '0)
                    begin
                        phase_next = lztsd_pkg::PH_OFF0;
                    end
                end
                lztsd_pkg::PH_OFF0:
                begin
                    match_offset_next = {8'd0, in_byte};
                    phase_next        = lztsd_pkg::PH_OFF1;
                end
                lztsd_pkg::PH_OFF1:
                begin
                    match_offset_next = off_full;
                    match_left_next   = LB'(match_nibble_reg) + LB'(lztsd_pkg::MIN_MATCH);
                    if (match_nibble_reg == lztsd_pkg::NIB_ESC)
                    begin
                        phase_next = lztsd_pkg::PH_MEXT;
                    end
                    else
                    begin
                        phase_next    = lztsd_pkg::PH_COPY;
                        end_seen_next = in_last;
                    end
                end
                lztsd_pkg::PH_MEXT:
                begin
                    match_left_next = match_sum;
                    if (in_byte != lztsd_pkg::EXT_CONT)
                    begin
                        phase_next    = lztsd_pkg::PH_COPY;
                        end_seen_next = in_last;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        // History write pointer and byte count
        if (push)
        begin
            wr_ptr_next = (wr_inc == (AW + 1)'(HISTORY_DEPTH)) ? '0 : wr_inc[AW-1:0];
            if (produced_reg != '1)
            begin
                produced_next = produced_reg + 32'd1;
            end
        end

        // End of block
        if (do_close)
        begin
            phase_next        = close_drain ? lztsd_pkg::PH_DRAIN : lztsd_pkg::PH_HDR;
            header_left_next  = lztsd_pkg::HDR_LEN;
            match_nibble_next = '0;
            literal_left_next = '0;
            match_left_next   = '0;
            match_offset_next = '0;
            end_seen_next     = 1'b0;
            produced_next     = '0;
            wr_ptr_next       = '0;
        end
    end

    // Parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= lztsd_pkg::PH_HDR;
            header_left_reg  <= lztsd_pkg::HDR_LEN;
            match_nibble_reg <= '0;
            literal_left_reg <= '0;
            match_left_reg   <= '0;
            match_offset_reg <= '0;
            end_seen_reg     <= 1'b0;
            produced_reg     <= '0;
            wr_ptr_reg       <= '0;
        end
        else if (in_accept)
        begin
            phase_reg        <= phase_next;
            header_left_reg  <= header_left_next;
            match_nibble_reg <= match_nibble_next;
            literal_left_reg <= literal_left_next;
            match_left_reg   <= match_left_next;
            match_offset_reg <= match_offset_next;
            end_seen_reg     <= end_seen_next;
            produced_reg     <= produced_next;
            wr_ptr_reg       <= wr_ptr_next;
        end
    end

    // History RAM: write from the stage, read at accept
    assign s1_data = !s1_copy_reg ? s1_lit_reg : (s1_fwd_reg ? s1_fwd_data_reg : ram_q);
    assign ram_we  = s1_valid_reg && s1_move && s1_wen_reg;

    lztsd_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_waddr_reg),
        .wdata (s1_data),
        .re    (in_accept && copy_go),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // Stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_has_res_reg <= 1'b0;
            s1_wen_reg     <= 1'b0;
        end
        else if (s1_move)
        begin
            s1_valid_reg   <= in_accept;
            s1_has_res_reg <= in_accept && res_valid;
            s1_wen_reg     <= in_accept && push;
        end
    end

    // Stage payload; forward when a copy read hits the byte written this cycle
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_res_reg      <= res;
            s1_waddr_reg    <= wr_ptr_reg;
            s1_copy_reg     <= is_copy;
            s1_lit_reg      <= res.has_data ? in_byte : 8'd0;
            s1_fwd_reg      <= is_copy && ram_we && (s1_waddr_reg == rd_addr);
            s1_fwd_data_reg <= s1_data;
        end
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= s1_valid_reg && s1_has_res_reg;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            out_res_reg  <= s1_res_reg;
            out_byte_reg <= s1_data;
        end
    end

    assign out_valid  = out_valid_reg;
    assign has_data   = out_res_reg.has_data;
    assign out_byte   = out_byte_reg;
    assign copy_left  = out_res_reg.copy_left;
    assign block_done = out_res_reg.block_done;
    assign status     = out_res_reg.status;

    // A held result means the output is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |-> (out_valid_reg && out_stall))
        else $error("stage held without a stalled output");

    // Forwarding only applies to copy steps
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_wen_reg && s1_fwd_reg) |-> s1_copy_reg)
        else $error("forward flag on a literal");

    // Copy phase always has match bytes pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == lztsd_pkg::PH_COPY) |-> (match_left_reg != '0))
        else $error("copy phase with no match bytes left");

    // Header phase always has header bytes pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == lztsd_pkg::PH_HDR) |-> (header_left_reg != 3'd0))
        else $error("header phase with no header bytes left");

    // A finishing result leaves the parser at a block boundary
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && res_valid && res.block_done)
            |=> ((produced_reg == '0) && (wr_ptr_reg == '0)))
        else $error("block finished without reset of history count");

endmodule

`default_nettype wire
